// ----- hdl/nsfs_pkg.sv -----
package nsfs_pkg;

  // Default sizes of the sentence layout.
  localparam int unsigned HeaderCharsDef = 6;
  localparam int unsigned FieldCountDef  = 16;
  localparam int unsigned FieldCharsDef  = 16;

  // Header register: up to eight characters, first character in the low byte.
  localparam int unsigned HdrMaxChars = 8;
  localparam int unsigned HdrWidth    = 8 * HdrMaxChars;
  localparam logic [HdrWidth-1:0] HdrReset = 64'h0000_434D_5250_4724; // "$GPRMC"

  // Counter widths cover the largest bounds (16 fields, 16 characters).
  localparam int unsigned CntWidth = 5;

  // The field that carries the navigation status character.
  localparam logic [CntWidth-1:0] StatusField = 5'd2;

  // Characters with a special meaning.
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharComma   = 8'h2C;
  localparam logic [7:0] CharStar    = 8'h2A;
  localparam logic [7:0] CharFixOk   = 8'h41;

  // Sentence status codes reported with each result.
  typedef enum logic [1:0] {
    STATUS_CONT  = 2'd0,
    STATUS_FIX   = 2'd1,
    STATUS_NOFIX = 2'd2
  } status_t;

  // One result transaction.
  typedef struct packed {
    status_t    status;
    logic       stored;
    logic [3:0] field;
    logic [3:0] pos;
    logic [7:0] char_val;
  } result_t;

endpackage

// ----- hdl/nsfs_core.sv -----
module nsfs_core import nsfs_pkg::*; #(
  parameter int unsigned HEADER_CHARS = HeaderCharsDef,
  parameter int unsigned FIELD_COUNT  = FieldCountDef,
  parameter int unsigned FIELD_CHARS  = FieldCharsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [HdrWidth-1:0] cfg_data,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output result_t             res,
  output logic                hdr_matched
);

  localparam logic [CntWidth-1:0] HdrLen   = CntWidth'(HEADER_CHARS);
  localparam logic [CntWidth-1:0] FldLimit = CntWidth'(FIELD_COUNT);
  localparam logic [CntWidth-1:0] PosLimit = CntWidth'(FIELD_CHARS);

  logic [HdrWidth-1:0] header_r;
  logic                matched_r, matched_nxt;
  logic [CntWidth-1:0] field_r, field_nxt;
  logic [CntWidth-1:0] pos_r, pos_nxt;
  logic [7:0]          fix_r, fix_nxt;
  logic [7:0]          hdr_chars [HdrMaxChars];
  logic [7:0]          want;
  logic                is_sep;

  // Split the header register into its characters.
  for (genvar i = 0; i < HdrMaxChars; i++) begin : g_hdr
    assign hdr_chars[i] = header_r[8*i +: 8];
  end

  assign want   = hdr_chars[pos_r[2:0]];
  assign is_sep = (byte_in == CharComma) || (byte_in == CharStar);

  // Per-byte parser decision.
  always_comb begin
    matched_nxt = matched_r;
    field_nxt   = field_r;
    pos_nxt     = pos_r;
    fix_nxt     = fix_r;
    res         = '0;
    res.status  = STATUS_CONT;
    if (byte_in == CharNewline) begin
      matched_nxt = 1'b0;
      field_nxt   = '0;
      pos_nxt     = '0;
      res.status  = (fix_r == CharFixOk) ? STATUS_FIX : STATUS_NOFIX;
    end else if (matched_r && is_sep) begin
      if (field_r < FldLimit) begin
        field_nxt = field_r + 1'b1;
      end
      pos_nxt = '0;
    end else if (!matched_r) begin
      // Header is matched as a subsequence: mismatching bytes are skipped.
      if (pos_r >= HdrLen || pos_r >= CntWidth'(HdrMaxChars)) begin
        matched_nxt = 1'b1;
      end else if (byte_in == want) begin
        pos_nxt = pos_r + 1'b1;
        if (pos_nxt >= HdrLen) begin
          matched_nxt = 1'b1;
        end
      end
    end else if (field_r < FldLimit && pos_r < PosLimit) begin
      res.stored   = 1'b1;
      res.field    = field_r[3:0];
      res.pos      = pos_r[3:0];
      res.char_val = byte_in;
      if (field_r == StatusField && pos_r == '0) begin
        fix_nxt = byte_in;
      end
      pos_nxt = pos_r + 1'b1;
    end
  end

  // Parser state and the header register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HdrReset;
      matched_r <= 1'b0;
      field_r   <= '0;
      pos_r     <= '0;
      fix_r     <= '0;
    end else begin
      if (cfg_we) begin
        header_r <= cfg_data;
      end
      if (step) begin
        matched_r <= matched_nxt;
        field_r   <= field_nxt;
        pos_r     <= pos_nxt;
        fix_r     <= fix_nxt;
      end
    end
  end

  assign hdr_matched = matched_r;

endmodule

// ----- hdl/nmea_sentence_field_splitter.sv -----
// NMEA sentence field splitter: takes one received character per input
// transaction and returns exactly one result transaction for it, telling
// whether the character was stored as field content (with its field number
// and position) and whether a newline ended the sentence with a valid fix.
// The header held in cfg_header_bytes (first character in the low byte,
// "$GPRMC" after reset) is matched as a subsequence before fields are
// split on ',' and '*'. Write the header only while no transaction is in
// flight. A character passes through an input register and a result
// register, so the block takes one character every clock cycle while out_stall
// does not hold the result register; the parser state loop holds a single
// register, which sets that rate.
module nmea_sentence_field_splitter import nsfs_pkg::*; #(
  parameter int unsigned HEADER_CHARS = HeaderCharsDef,
  parameter int unsigned FIELD_COUNT  = FieldCountDef,
  parameter int unsigned FIELD_CHARS  = FieldCharsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_received_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_sentence_status,
  output logic                out_byte_stored,
  output logic [3:0]          out_store_field,
  output logic [3:0]          out_store_position,
  output logic [7:0]          out_stored_char,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [HdrWidth-1:0] cfg_header_bytes
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  result_t    res;
  logic       out_free, s1_fire, in_fire, hdr_matched;

  // Handshake: the result register frees the input register.
  assign out_free      = !out_valid_r || !out_stall;
  assign s1_fire       = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_fire       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && out_stall);
  assign cfg_ready     = 1'b1;

  nsfs_core #(
    .HEADER_CHARS(HEADER_CHARS),
    .FIELD_COUNT (FIELD_COUNT),
    .FIELD_CHARS (FIELD_CHARS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_header_bytes),
    .step       (s1_fire),
    .byte_in    (s1_byte_r),
    .res        (res),
    .hdr_matched(hdr_matched)
  );

  // Valid flags of the input and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_received_byte;
    end
    if (s1_fire) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sentence_status = out_r.status;
  assign out_byte_stored     = out_r.stored;
  assign out_store_field     = out_r.field;
  assign out_store_position  = out_r.pos;
  assign out_stored_char     = out_r.char_val;

  // The input side only stalls while a character waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  // A newline always leaves the parser hunting for the header again.
  a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_byte_r == CharNewline) |=> !hdr_matched)
    else $error("header match survived a newline");

  // A sentence end never carries a stored character.
  a_end_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sentence_status != STATUS_CONT) |-> !out_byte_stored)
    else $error("stored character reported with a sentence end");

  // Stored characters only appear once the header has been matched.
  a_store_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res.stored) |-> hdr_matched)
    else $error("character stored before the header was matched");

endmodule
